// ----- rtl/core/dpct_pkg.sv -----
// Shared constants, configuration indexes and structs for the debounced
// pulse count trigger. No dependencies.
package dpct_pkg;

  localparam int TIME_W     = 32;
  localparam int DEBOUNCE_W = 16;
  localparam int TARGET_W   = 4;
  localparam int COUNT_W    = 4;
  localparam int TOGGLE_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [TARGET_W-1:0]   TARGET_RST   = 4'd3;
  localparam logic [TIME_W-1:0]     WINDOW_RST   = 32'd3000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_TARGET   = 2'd1,
    REG_WINDOW   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [DEBOUNCE_W-1:0] debounce_time;
    logic [TARGET_W-1:0]   pulse_target;
    logic [TIME_W-1:0]     window_time;
  } cfg_t;

  typedef struct packed {
    logic               stable_level;
    logic               trigger;
    logic [COUNT_W-1:0] pulse_count;
  } result_t;

endpackage

// ----- rtl/core/dpct_if.sv -----
// Valid/ready channel interfaces for switch samples and results.
// Depends on dpct_pkg.
interface dpct_in_if;
  import dpct_pkg::*;
  logic              valid;
  logic              ready;
  logic              pin_level;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, output pin_level, output now_ms, input ready);
  modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

interface dpct_out_if;
  import dpct_pkg::*;
  logic               valid;
  logic               ready;
  logic               stable_level;
  logic               trigger;
  logic [COUNT_W-1:0] pulse_count;

  modport source (output valid, output stable_level, output trigger, output pulse_count,
                  input ready);
  modport sink   (input valid, input stable_level, input trigger, input pulse_count,
                  output ready);
endinterface

// ----- rtl/core/dpct_cfg_regs.sv -----
// Configuration register bank: debounce time, pulse target and window length.
// Depends on dpct_pkg.
module dpct_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dpct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpct_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output dpct_pkg::cfg_t                 cfg
);
  import dpct_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time <= DEBOUNCE_RST;
      cfg_r.pulse_target  <= TARGET_RST;
      cfg_r.window_time   <= WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE: cfg_r.debounce_time <= cfg_wdata[DEBOUNCE_W-1:0];
        REG_TARGET:   cfg_r.pulse_target  <= cfg_wdata[TARGET_W-1:0];
        REG_WINDOW:   cfg_r.window_time   <= cfg_wdata[TIME_W-1:0];
        default:      ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/core/dpct_core.sv -----
// Debounce and pulse counting state with its single-sample update logic.
// Depends on dpct_pkg.
module dpct_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        pin_level,
  input  logic [dpct_pkg::TIME_W-1:0] now_ms,
  input  dpct_pkg::cfg_t              cfg,
  output dpct_pkg::result_t           res
);
  import dpct_pkg::*;

  logic                started_r,         started_nxt;
  logic                committed_level_r, committed_level_nxt;
  logic                change_pending_r,  change_pending_nxt;
  logic                pending_level_r,   pending_level_nxt;
  logic [TIME_W-1:0]   change_time_r,     change_time_nxt;
  logic [TOGGLE_W-1:0] toggle_count_r,    toggle_count_nxt;
  logic [COUNT_W-1:0]  on_count_r,        on_count_nxt;
  logic [TIME_W-1:0]   window_start_r,    window_start_nxt;

  logic                level_base;
  logic [TIME_W-1:0]   ws_base;
  logic                pend_new;
  logic                pend;
  logic                pend_lvl;
  logic [TIME_W-1:0]   chg_time;
  logic [TIME_W-1:0]   since_change;
  logic                abandon;
  logic                commit;
  logic [TOGGLE_W-1:0] tc_inc;
  logic                first_toggle;
  logic [COUNT_W-1:0]  oc_inc;
  logic [COUNT_W-1:0]  oc_commit;
  logic [TIME_W-1:0]   ws_commit;
  logic [TIME_W-1:0]   elapsed;
  logic                in_window;
  logic                fire;

  always_comb begin
    // The first sample after a restart latches the level and the window start.
    level_base = started_r ? committed_level_r : pin_level;
    ws_base    = started_r ? window_start_r : now_ms;

    pend_new = !change_pending_r && (pin_level != level_base);
    pend     = change_pending_r | pend_new;
    pend_lvl = pend_new ? pin_level : pending_level_r;
    chg_time = pend_new ? now_ms : change_time_r;

    since_change = now_ms - chg_time;
    abandon      = pend && (pin_level != pend_lvl);
    commit       = pend && !abandon &&
                   (since_change >= {{(TIME_W-DEBOUNCE_W){1'b0}}, cfg.debounce_time});

    tc_inc       = (toggle_count_r != {TOGGLE_W{1'b1}}) ? toggle_count_r + 1'b1
                                                        : toggle_count_r;
    first_toggle = (tc_inc == {{(TOGGLE_W-1){1'b0}}, 1'b1});
    oc_inc       = (!pend_lvl && (on_count_r != {COUNT_W{1'b1}})) ? on_count_r + 1'b1
                                                                   : on_count_r;
    oc_commit    = first_toggle ? {{(COUNT_W-1){1'b0}}, !pend_lvl} : oc_inc;
    ws_commit    = first_toggle ? now_ms : ws_base;
    elapsed      = now_ms - ws_commit;
    in_window    = (elapsed <= cfg.window_time);
    fire         = commit && in_window && (oc_commit >= cfg.pulse_target);

    started_nxt         = 1'b1;
    committed_level_nxt = level_base;
    change_pending_nxt  = pend;
    pending_level_nxt   = pend_lvl;
    change_time_nxt     = chg_time;
    toggle_count_nxt    = toggle_count_r;
    on_count_nxt        = on_count_r;
    window_start_nxt    = ws_base;

    if (abandon) begin
      change_pending_nxt = 1'b0;
    end
    if (commit) begin
      committed_level_nxt = pend_lvl;
      change_pending_nxt  = 1'b0;
      toggle_count_nxt    = tc_inc;
      on_count_nxt        = oc_commit;
      window_start_nxt    = ws_commit;
      if (!in_window) begin
        // The window ran out before this commit, so counting starts afresh.
        toggle_count_nxt = '0;
        on_count_nxt     = '0;
        window_start_nxt = now_ms;
      end
    end

    res.stable_level = committed_level_nxt;
    res.trigger      = fire;
    res.pulse_count  = on_count_nxt;

    if (fire) begin
      started_nxt         = 1'b0;
      committed_level_nxt = 1'b0;
      change_pending_nxt  = 1'b0;
      pending_level_nxt   = 1'b0;
      change_time_nxt     = '0;
      toggle_count_nxt    = '0;
      on_count_nxt        = '0;
      window_start_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r         <= 1'b0;
      committed_level_r <= 1'b0;
      change_pending_r  <= 1'b0;
      pending_level_r   <= 1'b0;
      change_time_r     <= '0;
      toggle_count_r    <= '0;
      on_count_r        <= '0;
      window_start_r    <= '0;
    end else if (step) begin
      started_r         <= started_nxt;
      committed_level_r <= committed_level_nxt;
      change_pending_r  <= change_pending_nxt;
      pending_level_r   <= pending_level_nxt;
      change_time_r     <= change_time_nxt;
      toggle_count_r    <= toggle_count_nxt;
      on_count_r        <= on_count_nxt;
      window_start_r    <= window_start_nxt;
    end
  end

endmodule

// ----- rtl/core/debounced_pulse_count_trigger.sv -----
// Top level of the debounced pulse count trigger: sample register, state update
// and result register. Depends on dpct_pkg, dpct_if, dpct_cfg_regs and dpct_core.
//
//   Channel   Direction  Carries
//   in_chan   sink       pin_level, now_ms (one switch sample)
//   out_chan  source     stable_level, trigger, pulse_count (one result)
//   cfg_*     write      debounce_time, pulse_target, window_time
//
// Every sample gives exactly one result, after the sample and result registers.
// A new sample is taken in every cycle while results are collected.
// The sample register and the result register together form the pipeline;
// the state update is combinational logic between them.
// A stalled result holds the pipeline; the sample register still fills once.
// Synchronous reset clears the valid flags and the core state; configuration returns to its defaults.
module debounced_pulse_count_trigger (
  input  logic                            clk,
  input  logic                            rst_n,
  dpct_in_if.sink                         in_chan,
  dpct_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [dpct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpct_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import dpct_pkg::*;

  cfg_t              cfg;
  result_t           res;
  logic              s1_valid_r;
  logic              s1_pin_r;
  logic [TIME_W-1:0] s1_now_r;
  logic              out_valid_r;
  result_t           out_res_r;
  logic              advance;
  logic              in_ready;
  logic              step;

  assign advance  = !out_valid_r || out_chan.ready;
  assign in_ready = rst_n && (!s1_valid_r || advance);
  assign step     = s1_valid_r && advance;

  dpct_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dpct_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .pin_level (s1_pin_r),
    .now_ms    (s1_now_r),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_chan.valid) begin
      s1_pin_r <= in_chan.pin_level;
      s1_now_r <= in_chan.now_ms;
    end
    if (step) begin
      out_res_r <= res;
    end
  end

  assign in_chan.ready         = in_ready;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.stable_level = out_res_r.stable_level;
  assign out_chan.trigger      = out_res_r.trigger;
  assign out_chan.pulse_count  = out_res_r.pulse_count;

endmodule

// ----- rtl/core/dpct_checker.sv -----
// Port-level checks for the debounced pulse count trigger, bound to the top
// level. Depends on dpct_pkg.
module dpct_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_stable_level,
  input logic                         out_trigger,
  input logic [dpct_pkg::COUNT_W-1:0] out_pulse_count
);
  import dpct_pkg::*;

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A result appears in an empty output only after a sample has passed the sample register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching sample");

  // The input is only held off while a result is stalled.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output back-pressure");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_stable_level) &&
                                   $stable(out_trigger) && $stable(out_pulse_count)))
    else $error("stalled result changed");

endmodule

bind debounced_pulse_count_trigger dpct_checker u_dpct_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_stable_level (out_chan.stable_level),
  .out_trigger      (out_chan.trigger),
  .out_pulse_count  (out_chan.pulse_count)
);

// ----- verif/debounced_pulse_count_trigger_tb.sv -----
// Self-checking testbench for the debounced pulse count trigger: directed and
// random switch samples, random back-pressure and several register settings.
// Depends on dpct_pkg, dpct_if and the debounced_pulse_count_trigger RTL.
module debounced_pulse_count_trigger_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dpct_pkg::*;

  localparam int LIMIT       = 1_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int PRINT_CAP   = 50;

  typedef struct packed {
    logic              pin;
    logic [TIME_W-1:0] now;
  } sample_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dpct_in_if  in_if();
  dpct_out_if out_if();

  debounced_pulse_count_trigger uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Register copies used by the predictor and by the stimulus generator.
  logic [DEBOUNCE_W-1:0] dbn_ms     = DEBOUNCE_RST;
  logic [TARGET_W-1:0]   pulse_goal = TARGET_RST;
  logic [TIME_W-1:0]     window_ms  = WINDOW_RST;

  // Predicted switch state.
  logic                sw_started  = 1'b0;
  logic                sw_level    = 1'b0;
  logic                chg_pending = 1'b0;
  logic                chg_level   = 1'b0;
  logic [TIME_W-1:0]   chg_time    = '0;
  logic [TOGGLE_W-1:0] toggles     = '0;
  logic [COUNT_W-1:0]  on_pulses   = '0;
  logic [TIME_W-1:0]   win_start   = '0;

  sample_t     pending_samples[$];
  result_t     expected_results[$];
  logic [31:0] gen_time = '0;
  int          queued_total = 0;
  int          samples_issued = 0;
  int          samples_taken = 0;
  int          mismatch_count = 0;
  int          triggers_seen = 0;
  int          settings_used = 1;
  int          cycle_count = 0;
  int          tx_gap = 0;
  int          tx_burst = 0;
  int          rx_stall = 0;
  int          rx_burst = 0;
  logic        sender_eager = 1'b0;
  logic        start_hold = 1'b0;
  logic        rx_hold = 1'b0;

  // Applies one switch sample to the predicted state and returns the result.
  function automatic result_t predict_switch(logic pin, logic [TIME_W-1:0] now);
    result_t           r;
    logic              fire;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] span;
    fire = 1'b0;
    if (!sw_started) begin
      sw_level   = pin;
      sw_started = 1'b1;
      win_start  = now;
    end
    if (!chg_pending && pin != sw_level) begin
      chg_pending = 1'b1;
      chg_level   = pin;
      chg_time    = now;
    end
    if (chg_pending) begin
      held = now - chg_time;
      if (pin != chg_level) begin
        chg_pending = 1'b0;
      end else if (held >= {16'd0, dbn_ms}) begin
        sw_level    = chg_level;
        chg_pending = 1'b0;
        if (toggles != 8'hFF) toggles = toggles + 1'b1;
        if (!sw_level && on_pulses != 4'hF) on_pulses = on_pulses + 1'b1;
        // The first toggle of a window restarts it.
        if (toggles == 8'd1) begin
          win_start = now;
          on_pulses = sw_level ? 4'd0 : 4'd1;
        end
        span = now - win_start;
        if (on_pulses >= pulse_goal && span <= window_ms) begin
          fire = 1'b1;
        end else if (span > window_ms) begin
          toggles   = '0;
          on_pulses = '0;
          win_start = now;
        end
      end
    end
    r.stable_level = sw_level;
    r.trigger      = fire;
    r.pulse_count  = on_pulses;
    if (fire) begin
      sw_started  = 1'b0;
      sw_level    = 1'b0;
      chg_pending = 1'b0;
      chg_level   = 1'b0;
      chg_time    = '0;
      toggles     = '0;
      on_pulses   = '0;
      win_start   = '0;
    end
    return r;
  endfunction

  // Mostly back-to-back, a few short gaps, rarely a long one; now and then a
  // burst with no gaps at all.
  function automatic int gap_len(ref int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r == 0) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 100) return 0;
    if (r < 180) return $urandom_range(1, 3);
    if (r < 196) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag_mismatch(string what);
    if (mismatch_count < PRINT_CAP) $display("[%0t] MISMATCH: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic queue_at(logic pin, logic [31:0] t);
    pending_samples.push_back('{pin: pin, now: t});
    gen_time = t;
    queued_total++;
  endtask

  task automatic queue_after(logic pin, logic [31:0] adv);
    queue_at(pin, gen_time + adv);
  endtask

  function automatic int bounce_step();
    return (dbn_ms < 3) ? 0 : $urandom_range(0, int'(dbn_ms) / 3);
  endfunction

  function automatic longint hold_span();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return longint'(dbn_ms) / 2;
    if (r < 8) return longint'(dbn_ms) + $urandom_range(0, int'(dbn_ms) / 2 + 4);
    return longint'(dbn_ms) + $urandom_range(0, window_ms / 4 + 1);
  endfunction

  // Holds one level for about span ms, optionally after some contact bounce.
  task automatic hold_level(logic level, longint span, logic bouncy);
    int     steps;
    longint stride;
    if (bouncy) begin
      repeat ($urandom_range(1, 3)) begin
        queue_after(level, bounce_step());
        queue_after(!level, bounce_step());
      end
    end
    queue_after(level, bounce_step());
    steps = $urandom_range(1, 4);
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    stride = (span + steps - 1) / steps;
    repeat (steps) queue_after(level, stride[31:0]);
  endtask

  task automatic press_series(int presses);
    repeat (presses) begin
      hold_level(1'b0, hold_span(), $urandom_range(0, 3) == 0);
      hold_level(1'b1, hold_span(), $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic random_mix(int n);
    int stop_at;
    stop_at = queued_total + n;
    while (queued_total < stop_at) begin
      case ($urandom_range(0, 9))
        7: hold_level(1'b1, longint'(window_ms) + 1 + $urandom_range(0, 100), 1'b0);
        8: repeat ($urandom_range(1, 8))
             queue_after(1'($urandom_range(0, 1)),
                         $urandom_range(0, int'(dbn_ms) * 2 + 10));
        9: queue_at(1'($urandom_range(0, 1)), $urandom);
        default: press_series($urandom_range(1, pulse_goal + 1));
      endcase
    end
  endtask

  // Returns once every queued sample has been taken and answered.
  task automatic wait_for_results();
    do @(posedge clk);
    while (pending_samples.size() != 0 || samples_issued != samples_taken ||
           expected_results.size() != 0);
  endtask

  task automatic write_settings(logic [15:0] dbn, logic [3:0] goal, logic [31:0] win);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEBOUNCE;
    cfg_wdata <= {16'd0, dbn};
    @(posedge clk);
    cfg_index <= REG_TARGET;
    cfg_wdata <= {28'd0, goal};
    @(posedge clk);
    cfg_index <= REG_WINDOW;
    cfg_wdata <= win;
    @(posedge clk);
    cfg_we <= 1'b0;
    dbn_ms     = dbn;
    pulse_goal = goal;
    window_ms  = win;
    settings_used++;
  endtask

  always @(posedge clk) begin : sample_driver
    sample_t s;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_results.push_back(predict_switch(in_if.pin_level, in_if.now_ms));
        samples_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (tx_gap > 0 && !sender_eager) begin
          in_if.valid <= 1'b0;
          tx_gap--;
        end else if (pending_samples.size() != 0) begin
          s = pending_samples.pop_front();
          in_if.valid     <= 1'b1;
          in_if.pin_level <= s.pin;
          in_if.now_ms    <= s.now;
          samples_issued++;
          tx_gap = gap_len(tx_burst);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (out_if.trigger) triggers_seen++;
        if (expected_results.size() == 0) begin
          flag_mismatch("result transaction arrived with none expected");
        end else begin
          want = expected_results.pop_front();
          if (out_if.stable_level !== want.stable_level)
            flag_mismatch($sformatf("stable_level got %b want %b",
                                    out_if.stable_level, want.stable_level));
          if (out_if.trigger !== want.trigger)
            flag_mismatch($sformatf("trigger got %b want %b",
                                    out_if.trigger, want.trigger));
          if (out_if.pulse_count !== want.pulse_count)
            flag_mismatch($sformatf("pulse_count got %0d want %0d",
                                    out_if.pulse_count, want.pulse_count));
        end
      end
      if (rx_hold) begin
        out_if.ready <= 1'b0;
      end else if (rx_stall > 0) begin
        out_if.ready <= 1'b0;
        rx_stall--;
      end else begin
        out_if.ready <= 1'b1;
        rx_stall = gap_len(rx_burst);
      end
    end
  end

  // The receiver holds off for a long stretch so that the pipeline fills.
  initial begin : receiver_holdoff
    wait (start_hold);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] win;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_DEBOUNCE;
    cfg_wdata       = '0;
    in_if.valid     = 1'b0;
    in_if.pin_level = 1'b0;
    in_if.now_ms    = '0;
    out_if.ready    = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings. A press sequence across the timestamp wrap, with one
    // abandoned change and a commit exactly at the debounce time, ending in
    // a trigger on the third ON pulse.
    queue_at(1'b1, 32'hFFFF_FFC0);
    queue_at(1'b0, 32'hFFFF_FFD0);
    queue_at(1'b1, 32'hFFFF_FFE0);
    queue_at(1'b0, 32'hFFFF_FFF0);
    queue_at(1'b0, 32'h0000_0021);
    queue_at(1'b0, 32'h0000_0022);
    queue_at(1'b1, 32'h0000_0030);
    queue_at(1'b1, 32'h0000_0062);
    queue_at(1'b0, 32'h0000_0070);
    queue_at(1'b0, 32'h0000_00A2);
    queue_at(1'b1, 32'h0000_00B0);
    queue_at(1'b1, 32'h0000_00E2);
    queue_at(1'b0, 32'h0000_00F0);
    queue_at(1'b0, 32'h0000_0122);
    // After the trigger the next sample starts afresh. A commit exactly at
    // the window edge keeps the counts; the next one past it clears them.
    queue_at(1'b0, 32'h0000_1000);
    queue_at(1'b1, 32'h0000_1010);
    queue_at(1'b1, 32'h0000_1042);
    queue_at(1'b0, 32'h0000_1050);
    queue_at(1'b0, 32'h0000_1082);
    queue_at(1'b1, 32'h0000_1090);
    queue_at(1'b1, 32'h0000_1BFA);
    queue_at(1'b0, 32'h0000_1C00);
    queue_at(1'b0, 32'h0000_1C40);
    random_mix(180);
    wait_for_results();

    // Zero debounce, single pulse target, zero-length window.
    write_settings(16'd0, 4'd1, 32'd0);
    random_mix(100);
    wait_for_results();

    // Longest debounce, highest target, widest window.
    write_settings(16'hFFFF, 4'd15, 32'hFFFF_FFFF);
    random_mix(160);
    wait_for_results();

    // A zero target fires on any commit inside the window.
    write_settings(16'($urandom_range(1, 100)), 4'd0, $urandom_range(200, 2000));
    random_mix(100);
    wait_for_results();

    // The sender keeps offering while the receiver is held off.
    write_settings(16'd20, 4'd4, 32'd1500);
    sender_eager = 1'b1;
    start_hold   = 1'b1;
    random_mix(250);
    wait_for_results();
    sender_eager = 1'b0;

    repeat (4) begin
      case ($urandom_range(0, 3))
        0:       win = $urandom_range(0, 200);
        3:       win = $urandom;
        default: win = $urandom_range(500, 8000);
      endcase
      write_settings(16'($urandom_range(0, 120)), 4'($urandom_range(1, 15)), win);
      random_mix(45);
      wait_for_results();
      random_mix(45);
      wait_for_results();
    end

    repeat (6) @(posedge clk);
    if (expected_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    $display("Checked %0d switch samples under %0d register settings; %0d triggers fired.",
             samples_taken, settings_used, triggers_seen);
    $display("Mismatches found: %0d", mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
